// ===== hw/rtl/ais_pkg.sv =====
// Shared types and constants for the address interval set unit.
package ais_pkg;

	localparam logic [1:0] MODE_CONTAINS = 2'd0;
	localparam logic [1:0] MODE_ADD      = 2'd1;
	localparam logic [1:0] MODE_REMOVE   = 2'd2;
	localparam logic [1:0] MODE_UNUSED   = 2'd3;

	typedef struct packed {
		logic load;
		logic rd;
		logic eval;
		logic emit2;
		logic tail;
		logic finish;
	} ais_cmd_t;

	typedef struct packed {
		logic bad_in;
		logic pend;
		logic more;
		logic out_busy;
	} ais_sts_t;

endpackage

// ===== hw/rtl/address_interval_set_unit.sv =====
// Each request is loaded while idle; then every stored interval is read and evaluated,
// with an extra write when an entry is inserted or split off during the scan, and a
// tail step and the result follow. One transaction at a time: the next is accepted
// once the unit returns to idle after the result, and a stalled result holds it back.
// Reset clears the interval count and control state; table contents need no clearing.
// Top level of the address interval set unit.
module address_interval_set_unit #(
	parameter int MAX_INTERVALS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           mode,
	input  logic [63:0]                          range_base,
	input  logic [63:0]                          range_size,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 ok,
	output logic [$clog2(MAX_INTERVALS+1)-1:0]   count_after
);
	import ais_pkg::*;

	ais_cmd_t cmd;
	ais_sts_t sts;
	logic     idle;

	ais_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle)
	);

	ais_dp #(.MAX_INTERVALS(MAX_INTERVALS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.range_base  (range_base),
		.range_size  (range_size),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.count_after (count_after)
	);

	assign in_stall = !idle;

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result dropped while stalled.");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count_after <= ($clog2(MAX_INTERVALS+1))'(MAX_INTERVALS))
		else $error("Interval count beyond table size.");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rd, cmd.eval, cmd.emit2, cmd.tail, cmd.finish}))
		else $error("Controller issued overlapping commands.");
`endif

endmodule

// ===== hw/rtl/ais_ctrl.sv =====
// Controller state machine that sequences one request through the table scan.
module ais_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ais_pkg::ais_sts_t sts,
	output ais_pkg::ais_cmd_t cmd,
	output logic              idle
);
	import ais_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_EMIT2, S_NEXT, S_TAIL, S_DONE} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (in_valid) state_q <= sts.bad_in ? S_DONE : S_NEXT;
				S_READ:  state_q <= S_EVAL;
				S_EVAL:  state_q <= sts.pend ? S_EMIT2 : S_NEXT;
				S_EMIT2: state_q <= S_NEXT;
				S_NEXT:  state_q <= sts.more ? S_READ : S_TAIL;
				S_TAIL:  state_q <= S_DONE;
				S_DONE:  if (!sts.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.rd     = (state_q == S_READ);
		cmd.eval   = (state_q == S_EVAL);
		cmd.emit2  = (state_q == S_EMIT2);
		cmd.tail   = (state_q == S_TAIL);
		cmd.finish = (state_q == S_DONE) && !sts.out_busy;
	end

	assign idle = (state_q == S_IDLE);

endmodule

// ===== hw/rtl/ais_dp.sv =====
// Datapath with the double-banked interval table and the merge and trim logic.
module ais_dp #(
	parameter int MAX_INTERVALS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ais_pkg::ais_cmd_t                    cmd,
	output ais_pkg::ais_sts_t                    sts,
	input  logic [1:0]                           mode,
	input  logic [63:0]                          range_base,
	input  logic [63:0]                          range_size,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 ok,
	output logic [$clog2(MAX_INTERVALS+1)-1:0]   count_after
);
	import ais_pkg::*;

	localparam int IW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 2);
	localparam int OW = $clog2(MAX_INTERVALS + 1);
	localparam int DEPTH = 2 ** (IW + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_INTERVALS);

	logic [63:0] mem_start [DEPTH];
	logic [63:0] mem_stop  [DEPTH];

	logic [63:0] lo_q, hi_q, s_q, e_q, pend_s_q, pend_e_q;
	logic [1:0]  mode_q;
	logic        bank_q, bad_q, merged_q, inserted_q, found_q, out_valid_q, ok_q;
	logic [CW-1:0] count_q, rptr_q, wptr_q;
	logic [OW-1:0] out_count_q;

	logic [64:0] sum;
	assign sum = {1'b0, range_base} + {1'b0, range_size};
	assign sts.bad_in = (range_size == 64'd0) || sum[64] ||
		!(mode == MODE_CONTAINS || mode == MODE_ADD || mode == MODE_REMOVE);

	logic        we;
	logic [63:0] w_s, w_e;
	logic        need_pend;
	logic [63:0] np_s, np_e;

	always_comb begin
		we = 1'b0;
		w_s = s_q;
		w_e = e_q;
		need_pend = 1'b0;
		np_s = s_q;
		np_e = e_q;
		if (cmd.eval) begin
			if (mode_q == MODE_ADD) begin
				if (inserted_q || e_q < lo_q) begin
					we = 1'b1;
				end else if (s_q > hi_q) begin
					we = 1'b1;
					w_s = lo_q;
					w_e = hi_q;
					need_pend = 1'b1;
				end
			end else if (mode_q == MODE_REMOVE) begin
				if (e_q <= lo_q || s_q >= hi_q) begin
					we = 1'b1;
				end else if (s_q < lo_q) begin
					we = 1'b1;
					w_e = lo_q;
					need_pend = e_q > hi_q;
					np_s = hi_q;
				end else if (e_q > hi_q) begin
					we = 1'b1;
					w_s = hi_q;
				end
			end
		end else if (cmd.emit2) begin
			we = 1'b1;
			w_s = pend_s_q;
			w_e = pend_e_q;
		end else if (cmd.tail) begin
			we = (mode_q == MODE_ADD) && !inserted_q;
			w_s = lo_q;
			w_e = hi_q;
		end
	end

	assign sts.pend = need_pend;
	assign sts.more = (rptr_q != count_q);
	assign sts.out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			s_q <= mem_start[{bank_q, rptr_q[IW-1:0]}];
			e_q <= mem_stop[{bank_q, rptr_q[IW-1:0]}];
		end
		if (we && wptr_q < MAX_C) begin
			mem_start[{~bank_q, wptr_q[IW-1:0]}] <= w_s;
			mem_stop[{~bank_q, wptr_q[IW-1:0]}]  <= w_e;
		end
	end

	logic res_ok;
	always_comb begin
		case (mode_q)
			MODE_CONTAINS: res_ok = found_q;
			MODE_ADD:      res_ok = !(count_q == MAX_C && !merged_q);
			MODE_REMOVE:   res_ok = (wptr_q <= MAX_C);
			default:       res_ok = 1'b0;
		endcase
		if (bad_q) res_ok = 1'b0;
	end

	logic flip;
	assign flip = res_ok && (mode_q != MODE_CONTAINS);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q   <= range_base;
			hi_q   <= sum[63:0];
			mode_q <= mode;
			bad_q  <= sts.bad_in;
		end else if (cmd.eval && mode_q == MODE_ADD && !inserted_q &&
			!(e_q < lo_q) && !(s_q > hi_q)) begin
			if (s_q < lo_q) lo_q <= s_q;
			if (e_q > hi_q) hi_q <= e_q;
		end
		if (cmd.eval) begin
			pend_s_q <= np_s;
			pend_e_q <= np_e;
		end
		if (cmd.finish) begin
			ok_q        <= res_ok;
			out_count_q <= flip ? OW'(wptr_q) : OW'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q      <= 1'b0;
			count_q     <= '0;
			rptr_q      <= '0;
			wptr_q      <= '0;
			merged_q    <= 1'b0;
			inserted_q  <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rptr_q     <= '0;
				wptr_q     <= '0;
				merged_q   <= 1'b0;
				inserted_q <= 1'b0;
				found_q    <= 1'b0;
			end else begin
				if (we) wptr_q <= wptr_q + CW'(1);
				if (cmd.eval) begin
					rptr_q <= rptr_q + CW'(1);
					if (mode_q == MODE_CONTAINS && s_q <= lo_q && hi_q <= e_q)
						found_q <= 1'b1;
					if (mode_q == MODE_ADD && !inserted_q) begin
						if (s_q > hi_q) inserted_q <= 1'b1;
						else if (!(e_q < lo_q)) merged_q <= 1'b1;
					end
				end
			end
			if (cmd.finish && flip) begin
				bank_q  <= ~bank_q;
				count_q <= wptr_q;
			end
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign count_after = out_count_q;

endmodule

// ===== test/ais_checker.sv =====
// Checker for the address interval set unit: predicts every result and compares it.
module ais_checker #(
	parameter int MAX_INTERVALS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [1:0]                         mode,
	input  logic [63:0]                        range_base,
	input  logic [63:0]                        range_size,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               ok,
	input  logic [$clog2(MAX_INTERVALS+1)-1:0] count_after,
	output int                                 fail_count,
	output int                                 pending
);
	import ais_pkg::*;

	localparam int CW = $clog2(MAX_INTERVALS + 1);

	typedef struct {
		logic          ok;
		logic [CW-1:0] count;
	} answer_t;

	logic [63:0] lo_tab [MAX_INTERVALS+1];
	logic [63:0] hi_tab [MAX_INTERVALS+1];
	int          n_iv;
	answer_t     answers [$];

	assign pending = answers.size();

	function automatic void move_entries(int from, int to);
		int k;
		if (to > from) begin
			for (k = n_iv - 1; k >= from; k--) begin
				lo_tab[k + to - from] = lo_tab[k];
				hi_tab[k + to - from] = hi_tab[k];
			end
		end else if (to < from) begin
			for (k = from; k < n_iv; k++) begin
				lo_tab[k + to - from] = lo_tab[k];
				hi_tab[k + to - from] = hi_tab[k];
			end
		end
	endfunction

	function automatic logic table_covers(logic [63:0] lo, logic [63:0] hi);
		for (int k = 0; k < n_iv; k++) begin
			if (lo_tab[k] > lo) return 1'b0;
			if (hi <= hi_tab[k]) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic table_merge(logic [63:0] lo, logic [63:0] hi);
		int first, last;
		first = 0;
		while (first < n_iv && hi_tab[first] < lo) first++;
		last = first;
		while (last < n_iv && lo_tab[last] <= hi) begin
			if (lo_tab[last] < lo) lo = lo_tab[last];
			if (hi_tab[last] > hi) hi = hi_tab[last];
			last++;
		end
		if (first == last && n_iv >= MAX_INTERVALS) return 1'b0;
		move_entries(last, first + 1);
		lo_tab[first] = lo;
		hi_tab[first] = hi;
		n_iv = n_iv - (last - first) + 1;
		return 1'b1;
	endfunction

	function automatic logic table_cut(logic [63:0] lo, logic [63:0] hi);
		int k;
		logic [63:0] s, e;
		if (n_iv >= MAX_INTERVALS)
			for (k = 0; k < n_iv; k++)
				if (lo_tab[k] < lo && hi < hi_tab[k]) return 1'b0;
		k = 0;
		while (k < n_iv) begin
			s = lo_tab[k];
			e = hi_tab[k];
			if (e <= lo) begin
				k++;
				continue;
			end
			if (s >= hi) break;
			if (s < lo && e > hi) begin
				move_entries(k + 1, k + 2);
				hi_tab[k] = lo;
				lo_tab[k + 1] = hi;
				hi_tab[k + 1] = e;
				n_iv++;
				break;
			end
			if (s < lo) begin
				hi_tab[k] = lo;
				k++;
			end else if (e > hi) begin
				lo_tab[k] = hi;
				break;
			end else begin
				move_entries(k + 1, k);
				n_iv--;
			end
		end
		return 1'b1;
	endfunction

	function automatic answer_t predict_request(logic [1:0] m, logic [63:0] b, logic [63:0] sz);
		answer_t a;
		logic [64:0] stop;
		stop = {1'b0, b} + {1'b0, sz};
		a.ok = 1'b0;
		if (sz != 0 && !stop[64]) begin
			case (m)
				MODE_CONTAINS: a.ok = table_covers(b, stop[63:0]);
				MODE_ADD:      a.ok = table_merge(b, stop[63:0]);
				MODE_REMOVE:   a.ok = table_cut(b, stop[63:0]);
				default:       a.ok = 1'b0;
			endcase
		end
		a.count = CW'(n_iv);
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		int      errs;
		if (!arst_n) begin
			n_iv = 0;
			answers.delete();
			fail_count <= 0;
		end else begin
			errs = 0;
			if (out_valid && !out_stall) begin
				if (answers.size() == 0) begin
					$error("result with no request waiting: ok=%0d count_after=%0d",
						ok, count_after);
					errs++;
				end else begin
					a = answers.pop_front();
					if (ok !== a.ok) begin
						$error("ok: expected %0d, actual %0d", a.ok, ok);
						errs++;
					end
					if (count_after !== a.count) begin
						$error("count_after: expected %0d, actual %0d", a.count, count_after);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
			if (in_valid && !in_stall)
				answers.push_back(predict_request(mode, range_base, range_size));
		end
	end
endmodule

// ===== test/tb.sv =====
// Testbench top for the address interval set unit: stimulus, idling and verdict.
module tb;
	import ais_pkg::*;

	localparam int MAXI = 16;
	localparam int CW = $clog2(MAXI + 1);
	localparam int STALL_LIMIT = 20000;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	logic [1:0]    mode;
	logic [63:0]   range_base;
	logic [63:0]   range_size;
	logic          out_valid;
	logic          out_stall;
	logic          ok;
	logic [CW-1:0] count_after;
	int            fail_count;
	int            pending;
	int            idle_pct;
	int            quiet_cycles;

	address_interval_set_unit #(.MAX_INTERVALS(MAXI)) u_dut (.*);

	ais_checker #(.MAX_INTERVALS(MAXI)) u_checker (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		arst_n = 1'b0;
		idle_pct = 23;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk)
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < idle_pct);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk)
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL address_interval_set_unit");
			$finish;
		end

	task automatic send_request(logic [1:0] m, logic [63:0] b, logic [63:0] sz);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		range_base <= b;
		range_size <= sz;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Most ranges come from a small window so that they overlap, touch and split often.
	task automatic send_random();
		logic [1:0]  m;
		logic [63:0] b, sz;
		int          pick;
		pick = $urandom_range(99);
		m = (pick < 40) ? MODE_ADD : (pick < 75) ? MODE_REMOVE : MODE_CONTAINS;
		b = 64'($urandom_range(400));
		sz = 64'($urandom_range(40, 1));
		pick = $urandom_range(99);
		if (pick < 4) begin
			m = MODE_UNUSED;
		end else if (pick < 7) begin
			sz = '0;
		end else if (pick < 12) begin
			b = {$urandom, $urandom};
			sz = {$urandom, $urandom};
		end else if (pick < 16) begin
			b = 64'hFFFF_FFFF_FFFF_FF00 + 64'($urandom_range(255));
			sz = 64'($urandom_range(300, 1));
		end
		send_request(m, b, sz);
	endtask

	initial begin
		in_valid = 1'b0;
		mode = MODE_CONTAINS;
		range_base = '0;
		range_size = '0;
		@(posedge arst_n);
		@(posedge clk);
		send_request(MODE_CONTAINS, 64'd0, 64'd1);
		send_request(MODE_ADD, 64'd100, 64'd0);
		send_request(MODE_ADD, '1, 64'd1);
		send_request(MODE_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10);
		send_request(MODE_CONTAINS, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10);
		send_request(MODE_UNUSED, 64'd10, 64'd10);
		send_request(MODE_ADD, 64'd100, 64'd10);
		send_request(MODE_ADD, 64'd110, 64'd10);
		send_request(MODE_ADD, 64'd90, 64'd5);
		send_request(MODE_CONTAINS, 64'd100, 64'd20);
		send_request(MODE_REMOVE, 64'd104, 64'd4);
		send_request(MODE_REMOVE, 64'd500, 64'd4);
		send_request(MODE_ADD, 64'd0, '1);
		send_request(MODE_REMOVE, 64'd0, '1);
		send_request(MODE_REMOVE, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10);
		for (int k = 0; k < 16; k++)
			send_request(MODE_ADD, 64'(k * 10), 64'd5);
		send_request(MODE_ADD, 64'd1000, 64'd5);
		send_request(MODE_REMOVE, 64'd1, 64'd2);
		send_request(MODE_ADD, 64'd5, 64'd5);
		send_request(MODE_REMOVE, 64'd1, 64'd2);
		for (int k = 0; k < 1900; k++) begin
			if (k == 600) idle_pct = 0;
			if (k == 900) idle_pct = 23;
			if (k % 300 == 299) send_request(MODE_REMOVE, 64'd0, '1);
			else send_random();
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (fail_count == 0)
			$display("PASS address_interval_set_unit");
		else
			$display("FAIL address_interval_set_unit");
		$finish;
	end
endmodule
